@@ sv/fpdq_pkg.sv @@
// ----------------------------------------------------------------------------
// fpdq_pkg: shared types for the Q16.16 fixed-point divider
// Word widths and payload types used by the channel interfaces and the core.
// ----------------------------------------------------------------------------
`default_nettype none

package fpdq_pkg;

   localparam int WORD_BITS = 32;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic        [WORD_BITS-1:0] uword_type;

endpackage

`default_nettype wire

@@ sv/fpdq_chan_if.sv @@
// ----------------------------------------------------------------------------
// fpdq_chan_if: valid/ready channels of the fixed-point divider
// One interface for operand words and one for result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpdq_req_if import fpdq_pkg::*;;
   logic     valid;
   logic     ready;
   word_type dividend;
   word_type divisor;

   modport source (output valid, output dividend, output divisor, input ready);
   modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface fpdq_rsp_if import fpdq_pkg::*;;
   logic     valid;
   logic     ready;
   word_type quotient;
   logic     divide_by_zero;

   modport source (output valid, output quotient, output divide_by_zero, input ready);
   modport sink   (input valid, input quotient, input divide_by_zero, output ready);
endinterface

`default_nettype wire

@@ sv/fixed_point_divide_q16.sv @@
// ----------------------------------------------------------------------------
// fixed_point_divide_q16: pipelined signed Q16.16 divider
// Divides two's complement fixed-point words, one quotient bit per stage.
// ----------------------------------------------------------------------------
// Usage.
// Operand words arrive on req_chan (dividend, divisor) and result words leave
// on rsp_chan (quotient, divide_by_zero); both are valid/ready channels, and
// a word moves on a rising edge at which valid and ready are both high.
// The magnitudes are divided as (|dividend| << FRACTION_BITS) / |divisor|,
// truncated toward zero; only the low 32 bits of the quotient are kept, and
// the sign is applied afterwards. A zero divisor yields a zero quotient with
// divide_by_zero set.
// Throughput is one word per cycle while the receiver does not stall. The
// pipeline is one operand register, 32 + FRACTION_BITS restoring subtract
// stages, each settling one quotient bit with a 33-bit subtract, and one
// output register that applies the sign.
// Every stage carries its own valid bit and loads whenever it is empty or
// the stage after it moves on, so bubbles close up when the receiver stalls
// and the block keeps taking words until the pipeline is full. Nothing is
// lost or repeated across a stall.
// A synchronous reset empties every stage; the operand data needs no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_divide_q16 import fpdq_pkg::*; #(
   parameter int FRACTION_BITS = 16
) (
   input  wire        clock,
   input  wire        reset,
   fpdq_req_if.sink   req_chan,
   fpdq_rsp_if.source rsp_chan
);

   // One restoring step per bit of the shifted dividend.
   localparam int NUM_BITS = WORD_BITS + FRACTION_BITS;
   localparam int STEPS    = NUM_BITS;

   // Stage 0 holds the operand magnitudes; stage s holds the state after s
   // subtract steps.
   logic                  stage_valid_ff [0:STEPS];
   logic                  stage_ready    [0:STEPS];
   logic [WORD_BITS-1:0]  rem_ff         [0:STEPS];
   logic [NUM_BITS-1:0]   num_ff         [0:STEPS];
   logic [WORD_BITS-1:0]  den_ff         [0:STEPS];
   logic [WORD_BITS-1:0]  quo_ff         [0:STEPS];
   logic                  neg_ff         [0:STEPS];
   logic                  zero_ff        [0:STEPS];

   logic                  out_valid_ff;
   logic                  out_ready;
   word_type              quotient_ff;
   logic                  dbz_ff;

   uword_type             dividend_mag;
   uword_type             divisor_mag;

   // The magnitude of the most negative word comes out as 2^31, which still
   // fits an unsigned word.
   assign dividend_mag = req_chan.dividend[WORD_BITS-1] ?
                         uword_type'(~req_chan.dividend + 1'b1) :
                         uword_type'(req_chan.dividend);
   assign divisor_mag  = req_chan.divisor[WORD_BITS-1] ?
                         uword_type'(~req_chan.divisor + 1'b1) :
                         uword_type'(req_chan.divisor);

   // A stage may load when it is empty or its contents move on this cycle.
   assign out_ready          = !out_valid_ff || rsp_chan.ready;
   assign stage_ready[STEPS] = !stage_valid_ff[STEPS] || out_ready;

   genvar s;
   generate
      for (s = 0; s < STEPS; s++) begin : g_ready
         assign stage_ready[s] = !stage_valid_ff[s] || stage_ready[s+1];
      end
   endgenerate

   assign req_chan.ready = stage_ready[0];

   // Operand register.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff[0] <= 1'b0;
      end else if (stage_ready[0]) begin
         stage_valid_ff[0] <= req_chan.valid;
      end
      if (stage_ready[0] && req_chan.valid) begin
         rem_ff[0]  <= '0;
         num_ff[0]  <= NUM_BITS'(dividend_mag) << FRACTION_BITS;
         den_ff[0]  <= divisor_mag;
         quo_ff[0]  <= '0;
         neg_ff[0]  <= req_chan.dividend[WORD_BITS-1] ^ req_chan.divisor[WORD_BITS-1];
         zero_ff[0] <= (req_chan.divisor == '0);
      end
   end

   // Restoring subtract stages.
   generate
      for (s = 1; s <= STEPS; s++) begin : g_step
         logic [WORD_BITS:0]   partial;
         logic [WORD_BITS:0]   trial;
         logic                 take;
         logic [WORD_BITS-1:0] rem_in;

         assign partial = {rem_ff[s-1], num_ff[s-1][NUM_BITS-1]};
         assign trial   = partial - {1'b0, den_ff[s-1]};
         assign take    = !trial[WORD_BITS];
         // The partial remainder stays below the divisor, so a kept partial
         // always fits in a word.
         assign rem_in  = take ? trial[WORD_BITS-1:0] : partial[WORD_BITS-1:0];

         always_ff @(posedge clock) begin
            if (reset) begin
               stage_valid_ff[s] <= 1'b0;
            end else if (stage_ready[s]) begin
               stage_valid_ff[s] <= stage_valid_ff[s-1];
            end
            if (stage_ready[s] && stage_valid_ff[s-1]) begin
               rem_ff[s]  <= rem_in;
               num_ff[s]  <= num_ff[s-1] << 1;
               den_ff[s]  <= den_ff[s-1];
               quo_ff[s]  <= {quo_ff[s-1][WORD_BITS-2:0], take};
               neg_ff[s]  <= neg_ff[s-1];
               zero_ff[s] <= zero_ff[s-1];
            end
         end
      end
   endgenerate

   // Output register: apply the sign, or force zero for a zero divisor.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= stage_valid_ff[STEPS];
      end
      if (out_ready && stage_valid_ff[STEPS]) begin
         if (zero_ff[STEPS]) begin
            quotient_ff <= '0;
         end else if (neg_ff[STEPS]) begin
            quotient_ff <= word_type'(~quo_ff[STEPS] + 1'b1);
         end else begin
            quotient_ff <= word_type'(quo_ff[STEPS]);
         end
         dbz_ff <= zero_ff[STEPS];
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.quotient       = quotient_ff;
   assign rsp_chan.divide_by_zero = dbz_ff;

   // A zero divisor must always come out as a zero quotient.
   a_zero_divisor_result : assert property (
      @(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.divide_by_zero |-> rsp_chan.quotient == '0
   ) else $error("divide by zero gave a non-zero quotient");

   // After the last step the remainder is below a non-zero divisor.
   a_final_remainder : assert property (
      @(posedge clock) disable iff (reset)
      stage_valid_ff[STEPS] && !zero_ff[STEPS] |-> rem_ff[STEPS] < den_ff[STEPS]
   ) else $error("final remainder not below divisor");

   // An accepted operand word lands in the operand register.
   a_accept_lands : assert property (
      @(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> stage_valid_ff[0]
   ) else $error("accepted operand word lost");

   // A stalled result word keeps the last step stage from handing over.
   a_stall_blocks_last : assert property (
      @(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready && stage_valid_ff[STEPS] |-> !stage_ready[STEPS]
   ) else $error("last stage would overwrite a stalled result");

endmodule

`default_nettype wire
